// File: hdl/vnsc_pkg.sv
// Shared types and constants for the nearest-seed color lookup block.
package vnsc_pkg;

   localparam int COORD_BITS        = 8;
   localparam int COLOR_BITS        = 24;
   localparam int INDEX_BITS        = 4;
   localparam int COUNT_BITS        = 4;
   localparam int SQUARE_BITS       = 2 * COORD_BITS;
   localparam int DIST_BITS         = SQUARE_BITS + 1;
   localparam int MAX_SEEDS_DEFAULT = 12;

   localparam logic [COUNT_BITS-1:0] SEED_COUNT_RESET = COUNT_BITS'(4);

   typedef enum logic [0:0] {
      OP_WRITE = 1'b0,
      OP_QUERY = 1'b1
   } op_type;

   typedef struct packed {
      op_type                  operation;
      logic [INDEX_BITS-1:0]   seed_index;
      logic [COORD_BITS-1:0]   seed_x;
      logic [COORD_BITS-1:0]   seed_y;
      logic [COLOR_BITS-1:0]   seed_color;
      logic [COORD_BITS-1:0]   pixel_x;
      logic [COORD_BITS-1:0]   pixel_y;
   } req_type;

   typedef struct packed {
      logic [COLOR_BITS-1:0]   pixel_color;
      logic [INDEX_BITS-1:0]   nearest_index;
      logic [DIST_BITS-1:0]    nearest_distance;
   } rsp_type;

   typedef struct packed {
      logic [COORD_BITS-1:0]   x;
      logic [COORD_BITS-1:0]   y;
      logic [COLOR_BITS-1:0]   color;
   } seed_type;

   typedef struct packed {
      logic write_seed;
      logic start;
      logic issue;
      logic load_out;
   } cmd_type;

   typedef struct packed {
      logic scan_last;
      logic done;
      logic out_free;
   } status_type;

endpackage

// File: hdl/vnsc_datapath.sv
// Seed table, distance pipeline, running minimum and response register.
module vnsc_datapath #(
   parameter int MAX_SEEDS = vnsc_pkg::MAX_SEEDS_DEFAULT
) (
   input  logic                                clock,
   input  logic                                reset,
   input  vnsc_pkg::req_type                   req_payload,
   input  vnsc_pkg::cmd_type                   cmd,
   output vnsc_pkg::status_type                sts,
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output vnsc_pkg::rsp_type                   rsp_payload,
   input  logic                                csr_wr_en,
   input  logic [vnsc_pkg::COUNT_BITS-1:0]     csr_wr_data
);
   import vnsc_pkg::*;

   localparam int IW = (MAX_SEEDS > 1) ? $clog2(MAX_SEEDS) : 1;

   seed_type                 seed_mem [MAX_SEEDS];

   logic [COUNT_BITS-1:0]    seed_count_ff, seed_count_in;
   logic [IW-1:0]            last_idx_ff, last_idx_in;
   logic [IW-1:0]            scan_cnt_ff, scan_cnt_in;
   logic [COORD_BITS-1:0]    pixel_x_ff, pixel_y_ff;

   logic                     s1_valid_ff, s1_first_ff, s1_last_ff;
   logic [IW-1:0]            s1_idx_ff;
   seed_type                 rd_seed_ff;

   logic                     s2_valid_ff, s2_first_ff, s2_last_ff;
   logic [IW-1:0]            s2_idx_ff;
   logic [COLOR_BITS-1:0]    s2_color_ff;
   logic [SQUARE_BITS-1:0]   dx2_ff, dy2_ff;

   logic [COORD_BITS-1:0]    dx, dy;
   logic [DIST_BITS-1:0]     dist_sum;
   logic                     take_best;

   logic [DIST_BITS-1:0]     best_dist_ff;
   logic [IW-1:0]            best_idx_ff;
   logic [COLOR_BITS-1:0]    best_color_ff;
   logic                     done_ff;

   logic                     rsp_valid_ff, rsp_valid_in;
   rsp_type                  rsp_data_ff;

   logic                     wr_hit;
   seed_type                 wr_seed;

   // Configuration register
   always_comb begin
      seed_count_in = seed_count_ff;
      if (csr_wr_en) begin
         seed_count_in = csr_wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         seed_count_ff <= SEED_COUNT_RESET;
      end else begin
         seed_count_ff <= seed_count_in;
      end
   end

   // Saturate the active count to 1..MAX_SEEDS and keep its last index
   always_comb begin
      if (seed_count_ff == '0) begin
         last_idx_in = '0;
      end else if (32'(seed_count_ff) > MAX_SEEDS) begin
         last_idx_in = IW'(MAX_SEEDS - 1);
      end else begin
         last_idx_in = IW'(seed_count_ff - COUNT_BITS'(1));
      end
   end

   // Seed table
   assign wr_hit        = cmd.write_seed && (32'(req_payload.seed_index) < MAX_SEEDS);
   assign wr_seed.x     = req_payload.seed_x;
   assign wr_seed.y     = req_payload.seed_y;
   assign wr_seed.color = req_payload.seed_color;

   always_ff @(posedge clock) begin
      if (wr_hit) begin
         seed_mem[IW'(req_payload.seed_index)] <= wr_seed;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.issue) begin
         rd_seed_ff <= seed_mem[scan_cnt_ff];
      end
   end

   // Scan counter
   always_comb begin
      scan_cnt_in = scan_cnt_ff;
      if (cmd.start) begin
         scan_cnt_in = '0;
      end else if (cmd.issue) begin
         scan_cnt_in = scan_cnt_ff + IW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         scan_cnt_ff <= '0;
      end else begin
         scan_cnt_ff <= scan_cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.start) begin
         last_idx_ff <= last_idx_in;
         pixel_x_ff  <= req_payload.pixel_x;
         pixel_y_ff  <= req_payload.pixel_y;
      end
   end

   // Stage 1: table read
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= cmd.issue;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.issue) begin
         s1_first_ff <= (scan_cnt_ff == '0);
         s1_last_ff  <= sts.scan_last;
         s1_idx_ff   <= scan_cnt_ff;
      end
   end

   // Stage 2: absolute differences and squares
   assign dx = (pixel_x_ff >= rd_seed_ff.x) ? (pixel_x_ff - rd_seed_ff.x)
                                            : (rd_seed_ff.x - pixel_x_ff);
   assign dy = (pixel_y_ff >= rd_seed_ff.y) ? (pixel_y_ff - rd_seed_ff.y)
                                            : (rd_seed_ff.y - pixel_y_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_valid_ff <= 1'b0;
      end else begin
         s2_valid_ff <= s1_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_valid_ff) begin
         s2_first_ff <= s1_first_ff;
         s2_last_ff  <= s1_last_ff;
         s2_idx_ff   <= s1_idx_ff;
         s2_color_ff <= rd_seed_ff.color;
         dx2_ff      <= SQUARE_BITS'(dx * dx);
         dy2_ff      <= SQUARE_BITS'(dy * dy);
      end
   end

   // Stage 3: sum and keep the minimum, lowest index on ties
   assign dist_sum  = DIST_BITS'(dx2_ff) + DIST_BITS'(dy2_ff);
   assign take_best = s2_valid_ff && (s2_first_ff || (dist_sum < best_dist_ff));

   always_ff @(posedge clock) begin
      if (take_best) begin
         best_dist_ff  <= dist_sum;
         best_idx_ff   <= s2_idx_ff;
         best_color_ff <= s2_color_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         done_ff <= 1'b0;
      end else begin
         done_ff <= s2_valid_ff && s2_last_ff;
      end
   end

   // Response register
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (cmd.load_out) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load_out) begin
         rsp_data_ff.pixel_color      <= best_color_ff;
         rsp_data_ff.nearest_index    <= INDEX_BITS'(best_idx_ff);
         rsp_data_ff.nearest_distance <= best_dist_ff;
      end
   end

   assign sts.scan_last = (scan_cnt_ff == last_idx_ff);
   assign sts.done      = done_ff;
   assign sts.out_free  = !rsp_valid_ff || rsp_ready;

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_data_ff;

endmodule

// File: hdl/vnsc_ctrl.sv
// Controller state machine: accepts beats, sequences the seed scan, hands off the result.
module vnsc_ctrl (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  vnsc_pkg::op_type      req_operation,
   input  vnsc_pkg::status_type  sts,
   output vnsc_pkg::cmd_type     cmd
);
   import vnsc_pkg::*;

   typedef enum logic [3:0] {
      ST_IDLE    = 4'b0001,
      ST_SCAN    = 4'b0010,
      ST_DRAIN   = 4'b0100,
      ST_RESPOND = 4'b1000
   } state_type;

   state_type state_ff, state_in;

   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      req_ready = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               if (req_operation == OP_QUERY) begin
                  cmd.start = 1'b1;
                  state_in  = ST_SCAN;
               end else begin
                  cmd.write_seed = 1'b1;
               end
            end
         end
         ST_SCAN: begin
            cmd.issue = 1'b1;
            if (sts.scan_last) begin
               state_in = ST_DRAIN;
            end
         end
         ST_DRAIN: begin
            if (sts.done) begin
               state_in = ST_RESPOND;
            end
         end
         ST_RESPOND: begin
            if (sts.out_free) begin
               cmd.load_out = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

// File: hdl/voronoi_nearest_seed_color.sv
// Top level of the nearest-seed color lookup over a small seed table.
//
//   port group   dir   carries
//   req_*        in    seed write or pixel query beat
//   rsp_*        out   color, index and squared distance of the nearest seed
//   csr_*        in    seed_count write, no wait
//
// A seed write is stored in its accept cycle. With n the seed_count held to 1..MAX_SEEDS,
// a pixel query makes n table reads through the single read port, then squares, then sums
// and compares, then registers the scan end, and loads its response once the response
// register is free; the next beat is taken the cycle after the load.
// Reset is synchronous; the seed table holds garbage until written. A response waiting
// on rsp_ready does not block the next beat, only the next response load.
module voronoi_nearest_seed_color #(
   parameter int MAX_SEEDS = vnsc_pkg::MAX_SEEDS_DEFAULT
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_valid,
   output logic                               req_ready,
   input  vnsc_pkg::req_type                  req_payload,
   output logic                               rsp_valid,
   input  logic                               rsp_ready,
   output vnsc_pkg::rsp_type                  rsp_payload,
   input  logic                               csr_wr_en,
   input  logic [vnsc_pkg::COUNT_BITS-1:0]    csr_wr_data
);
   import vnsc_pkg::*;

   cmd_type    cmd;
   status_type sts;

   vnsc_ctrl u_ctrl (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_ready     (req_ready),
      .req_operation (req_payload.operation),
      .sts           (sts),
      .cmd           (cmd)
   );

   vnsc_datapath #(
      .MAX_SEEDS (MAX_SEEDS)
   ) u_datapath (
      .clock       (clock),
      .reset       (reset),
      .req_payload (req_payload),
      .cmd         (cmd),
      .sts         (sts),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_payload (rsp_payload),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

endmodule

// File: tb/sv/voronoi_nearest_seed_color_tb.sv
// Testbench for voronoi_nearest_seed_color: seed writes, pixel queries and seed_count settings.
`timescale 1ns / 100ps

module voronoi_nearest_seed_color_tb;
   import vnsc_pkg::*;

   localparam int NUM_SEEDS    = MAX_SEEDS_DEFAULT;
   localparam int DRAIN_CYCLES = NUM_SEEDS + 8;
   localparam int HOLD_CYCLES  = 400;
   localparam int STALL_LIMIT  = 4000;
   localparam int PHASE_BEATS  = 190;
   localparam int PRESS_BEATS  = 60;

   logic                  clock;
   logic                  reset;
   logic                  req_valid;
   logic                  req_ready;
   req_type               req_payload;
   logic                  rsp_valid;
   logic                  rsp_ready;
   rsp_type               rsp_payload;
   logic                  csr_wr_en;
   logic [COUNT_BITS-1:0] csr_wr_data;

   logic [COORD_BITS-1:0] seed_x_tab     [NUM_SEEDS];
   logic [COORD_BITS-1:0] seed_y_tab     [NUM_SEEDS];
   logic [COLOR_BITS-1:0] seed_color_tab [NUM_SEEDS];
   logic [COUNT_BITS-1:0] seed_count_cfg;
   rsp_type               pending_colors [$];

   int fail_count;
   int quiet_cycles;
   int sender_idle_pct;
   int receiver_stall_pct;
   bit hold_rsp;

   voronoi_nearest_seed_color #(
      .MAX_SEEDS (NUM_SEEDS)
   ) dut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_payload (rsp_payload),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   always #5 clock = ~clock;

   function automatic rsp_type nearest_seed(input logic [COORD_BITS-1:0] px,
                                            input logic [COORD_BITS-1:0] py);
      rsp_type r;
      int      n;
      int      i;
      int      dx;
      int      dy;
      int      d;
      int      best_d;
      int      best_i;
      n = seed_count_cfg;
      if (n < 1) n = 1;
      if (n > NUM_SEEDS) n = NUM_SEEDS;
      best_i = 0;
      best_d = 0;
      for (i = 0; i < n; i++) begin
         dx = int'(px) - int'(seed_x_tab[i]);
         dy = int'(py) - int'(seed_y_tab[i]);
         d  = dx * dx + dy * dy;
         if (i == 0 || d < best_d) begin
            best_d = d;
            best_i = i;
         end
      end
      r.pixel_color      = seed_color_tab[best_i];
      r.nearest_index    = best_i[INDEX_BITS-1:0];
      r.nearest_distance = best_d[DIST_BITS-1:0];
      return r;
   endfunction

   function automatic req_type seed_beat(input int idx, input int x, input int y,
                                         input logic [COLOR_BITS-1:0] color);
      req_type b;
      b.operation  = OP_WRITE;
      b.seed_index = idx[INDEX_BITS-1:0];
      b.seed_x     = x[COORD_BITS-1:0];
      b.seed_y     = y[COORD_BITS-1:0];
      b.seed_color = color;
      b.pixel_x    = COORD_BITS'($urandom_range(255));
      b.pixel_y    = COORD_BITS'($urandom_range(255));
      return b;
   endfunction

   function automatic req_type pixel_beat(input int x, input int y);
      req_type b;
      b.operation  = OP_QUERY;
      b.seed_index = INDEX_BITS'($urandom_range(15));
      b.seed_x     = COORD_BITS'($urandom_range(255));
      b.seed_y     = COORD_BITS'($urandom_range(255));
      b.seed_color = COLOR_BITS'($urandom_range(24'hFFFFFF));
      b.pixel_x    = x[COORD_BITS-1:0];
      b.pixel_y    = y[COORD_BITS-1:0];
      return b;
   endfunction

   function automatic req_type random_beat(input bit query_only);
      req_type b;
      int      pick;
      b = pixel_beat($urandom_range(255), $urandom_range(255));
      pick = $urandom_range(NUM_SEEDS - 1);
      if (!query_only && $urandom_range(3) == 0) begin
         b.operation = OP_WRITE;
         if ($urandom_range(7) == 0) begin
            b.seed_x = seed_x_tab[pick];
            b.seed_y = seed_y_tab[pick];
         end
      end else if ($urandom_range(5) == 0) begin
         b.pixel_x = seed_x_tab[pick];
         b.pixel_y = seed_y_tab[pick];
      end
      return b;
   endfunction

   task automatic send_beat(input req_type b);
      @(negedge clock);
      while ($urandom_range(99) < sender_idle_pct) begin
         req_valid = 1'b0;
         @(negedge clock);
      end
      req_valid   = 1'b1;
      req_payload = b;
      do @(posedge clock); while (!req_ready);
      if (b.operation == OP_WRITE) begin
         if (b.seed_index < NUM_SEEDS) begin
            seed_x_tab[b.seed_index]     = b.seed_x;
            seed_y_tab[b.seed_index]     = b.seed_y;
            seed_color_tab[b.seed_index] = b.seed_color;
         end
      end else begin
         pending_colors.push_back(nearest_seed(b.pixel_x, b.pixel_y));
      end
   endtask

   task automatic wait_idle();
      @(negedge clock);
      req_valid = 1'b0;
      while (pending_colors.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic set_seed_count(input logic [COUNT_BITS-1:0] value);
      wait_idle();
      @(negedge clock);
      csr_wr_en   = 1'b1;
      csr_wr_data = value;
      @(negedge clock);
      csr_wr_en      = 1'b0;
      seed_count_cfg = value;
   endtask

   task automatic log_mismatch(input string field, input logic [31:0] expected,
                               input logic [31:0] actual);
      fail_count++;
      if (fail_count <= 10)
         $display("mismatch %s: expected 0x%0h, actual 0x%0h", field, expected, actual);
   endtask

   always @(negedge clock) begin
      rsp_ready = !hold_rsp && ($urandom_range(99) >= receiver_stall_pct);
   end

   always @(posedge clock) begin
      rsp_type exp_rsp;
      if (!reset && rsp_valid && rsp_ready) begin
         if (pending_colors.size() == 0) begin
            log_mismatch("unexpected beat", 32'h0, 32'(rsp_payload.pixel_color));
         end else begin
            exp_rsp = pending_colors.pop_front();
            if (rsp_payload.pixel_color !== exp_rsp.pixel_color)
               log_mismatch("pixel_color", 32'(exp_rsp.pixel_color),
                            32'(rsp_payload.pixel_color));
            if (rsp_payload.nearest_index !== exp_rsp.nearest_index)
               log_mismatch("nearest_index", 32'(exp_rsp.nearest_index),
                            32'(rsp_payload.nearest_index));
            if (rsp_payload.nearest_distance !== exp_rsp.nearest_distance)
               log_mismatch("nearest_distance", 32'(exp_rsp.nearest_distance),
                            32'(rsp_payload.nearest_distance));
         end
      end
   end

   always @(posedge clock) begin
      if ((req_valid && req_ready) || (rsp_valid && rsp_ready))
         quiet_cycles = 0;
      else
         quiet_cycles++;
      if (quiet_cycles >= STALL_LIMIT) begin
         $display("voronoi_nearest_seed_color test failed");
         $finish;
      end
   end

   task automatic test_seed_load();
      int i;
      send_beat(seed_beat(0, 0, 0, 24'h000000));
      send_beat(seed_beat(1, 255, 255, 24'hFFFFFF));
      send_beat(seed_beat(2, 0, 255, 24'hFF0000));
      send_beat(seed_beat(3, 255, 0, 24'h00FF00));
      send_beat(seed_beat(4, 128, 128, 24'h0000FF));
      send_beat(seed_beat(5, 128, 128, 24'h123456));
      for (i = 6; i < NUM_SEEDS; i++)
         send_beat(seed_beat(i, $urandom_range(255), $urandom_range(255),
                             COLOR_BITS'($urandom_range(24'hFFFFFF))));
      send_beat(seed_beat(12, 17, 17, 24'hABCDEF));
      send_beat(seed_beat(15, 255, 255, 24'hFFFFFF));
   endtask

   task automatic test_corner_queries();
      send_beat(pixel_beat(0, 0));
      send_beat(pixel_beat(255, 255));
      send_beat(pixel_beat(255, 0));
      send_beat(pixel_beat(0, 255));
      send_beat(pixel_beat(128, 128));
   endtask

   task automatic test_seed_count_limits();
      set_seed_count(4'd1);
      send_beat(pixel_beat(255, 255));
      set_seed_count(4'd0);
      send_beat(pixel_beat(200, 10));
      set_seed_count(4'd15);
      send_beat(pixel_beat(128, 128));
      set_seed_count(4'd12);
      send_beat(pixel_beat(128, 127));
   endtask

   task automatic test_random_traffic();
      int sender_pct   [4] = '{0, 46, 0, 7};
      int receiver_pct [4] = '{0, 0, 46, 7};
      int count_edge   [4] = '{12, 1, 0, 15};
      int phase;
      int part;
      int n;
      for (phase = 0; phase < 4; phase++) begin
         for (part = 0; part < 2; part++) begin
            set_seed_count(COUNT_BITS'(part == 0 ? count_edge[phase] : $urandom_range(15)));
            sender_idle_pct    = sender_pct[phase];
            receiver_stall_pct = receiver_pct[phase];
            for (n = 0; n < PHASE_BEATS; n++)
               send_beat(random_beat(1'b0));
         end
      end
      sender_idle_pct    = 0;
      receiver_stall_pct = 0;
   endtask

   task automatic test_response_backpressure();
      int n;
      set_seed_count(4'd12);
      fork
         begin
            hold_rsp = 1'b1;
            repeat (HOLD_CYCLES) @(posedge clock);
            hold_rsp = 1'b0;
         end
         for (n = 0; n < PRESS_BEATS; n++)
            send_beat(random_beat(1'b1));
      join
   endtask

   initial begin
      clock              = 1'b0;
      reset              = 1'b1;
      req_valid          = 1'b0;
      req_payload        = '0;
      rsp_ready          = 1'b0;
      csr_wr_en          = 1'b0;
      csr_wr_data        = '0;
      seed_count_cfg     = SEED_COUNT_RESET;
      fail_count         = 0;
      quiet_cycles       = 0;
      sender_idle_pct    = 0;
      receiver_stall_pct = 0;
      hold_rsp           = 1'b0;
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      test_seed_load();
      test_corner_queries();
      test_seed_count_limits();
      test_random_traffic();
      test_response_backpressure();
      wait_idle();

      if (fail_count == 0)
         $display("voronoi_nearest_seed_color test passed");
      else
         $display("voronoi_nearest_seed_color test failed");
      $finish;
   end

endmodule

// File: filelist.f
hdl/vnsc_pkg.sv
hdl/vnsc_datapath.sv
hdl/vnsc_ctrl.sv
hdl/voronoi_nearest_seed_color.sv
tb/sv/voronoi_nearest_seed_color_tb.sv
